@@ design/weighted_motion_predictor_macros.svh @@
// Assertion macros shared by the weighted motion predictor RTL.
`ifndef WEIGHTED_MOTION_PREDICTOR_MACROS_SVH
`define WEIGHTED_MOTION_PREDICTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during rst.
`define WMP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, sampled on clk, off during rst.
`define WMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define WMP_ASSERT_IMPL(lbl, ante, cons)
`define WMP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/wmp_pkg.sv @@
// Package: widths, stage-advance struct and divider constants of the predictor.
package wmp_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEPTH      = 5;
  localparam int CNT_BITS   = 3;
  localparam int OUT_BITS   = 14;

  localparam int TERM_BITS  = COORD_BITS + 3;
  localparam int SUM_BITS   = COORD_BITS + 5;
  localparam int T_BITS     = COORD_BITS + 4;
  localparam int K_SHIFT    = T_BITS + 4;
  localparam int RECIP_BITS = K_SHIFT + 1;
  localparam int PROD_BITS  = T_BITS + RECIP_BITS;
  localparam int WIDE_BITS  = (COORD_BITS + 5 > OUT_BITS) ? COORD_BITS + 5 : OUT_BITS;

  localparam logic [RECIP_BITS-1:0] RECIP_D1 = {1'b1, {K_SHIFT{1'b0}}};
  localparam logic [RECIP_BITS-1:0] RECIP_D3 =
    RECIP_BITS'(((64'd1 << K_SHIFT) + 64'd2) / 64'd3);
  localparam logic [RECIP_BITS-1:0] RECIP_D6 =
    RECIP_BITS'(((64'd1 << K_SHIFT) + 64'd5) / 64'd6);
  localparam logic [RECIP_BITS-1:0] RECIP_D10 =
    RECIP_BITS'(((64'd1 << K_SHIFT) + 64'd9) / 64'd10);

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } wmp_adv_t;

  // Reciprocal of the weight total m(m+1)/2 for a given point count.
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] cnt);
    logic [RECIP_BITS-1:0] r;
    unique case (cnt)
      3'd3:    r = RECIP_D3;
      3'd4:    r = RECIP_D6;
      3'd5:    r = RECIP_D10;
      default: r = RECIP_D1;
    endcase
    return r;
  endfunction

  // Half the weight total, rounded down: turns floor division into round-half-up.
  function automatic logic [T_BITS-1:0] half(input logic [CNT_BITS-1:0] cnt);
    logic [T_BITS-1:0] h;
    unique case (cnt)
      3'd3:    h = T_BITS'(1);
      3'd4:    h = T_BITS'(3);
      3'd5:    h = T_BITS'(5);
      default: h = '0;
    endcase
    return h;
  endfunction

endpackage

@@ design/wmp_cell.sv @@
// History cell: one stored point plus its weighted difference to the older neighbor.
module wmp_cell
  import wmp_pkg::*;
(
  input  logic                        clk,
  input  logic                        advance,
  input  logic [COORD_BITS-1:0]       din_x,
  input  logic [COORD_BITS-1:0]       din_y,
  input  logic [COORD_BITS-1:0]       down_x,
  input  logic [COORD_BITS-1:0]       down_y,
  input  logic [CNT_BITS-1:0]         weight,
  output logic [COORD_BITS-1:0]       point_x,
  output logic [COORD_BITS-1:0]       point_y,
  output logic signed [TERM_BITS-1:0] term_x,
  output logic signed [TERM_BITS-1:0] term_y
);

  logic signed [COORD_BITS:0]  diff_x;
  logic signed [COORD_BITS:0]  diff_y;
  logic signed [TERM_BITS-1:0] wgt;

  // Take the upstream point on each accepted request.
  always_ff @(posedge clk) begin
    if (advance) begin
      point_x <= din_x;
      point_y <= din_y;
    end
  end

  assign diff_x = $signed({1'b0, point_x}) - $signed({1'b0, down_x});
  assign diff_y = $signed({1'b0, point_y}) - $signed({1'b0, down_y});
  assign wgt    = TERM_BITS'($signed({1'b0, weight}));
  // Drop the term outright at zero weight: the points behind it may never
  // have been written.
  assign term_x = (weight == '0) ? TERM_BITS'(0) : TERM_BITS'(diff_x) * wgt;
  assign term_y = (weight == '0) ? TERM_BITS'(0) : TERM_BITS'(diff_y) * wgt;

endmodule

@@ design/wmp_div.sv @@
// Rounding divider for one coordinate: weighted sum / weight total, plus newest point.
module wmp_div
  import wmp_pkg::*;
(
  input  logic                       clk,
  input  wmp_adv_t                   adv,
  input  logic signed [SUM_BITS-1:0] sum,
  input  logic [COORD_BITS-1:0]      h0,
  input  logic [CNT_BITS-1:0]        cnt_s1,
  input  logic [CNT_BITS-1:0]        cnt_s2,
  output logic [OUT_BITS-1:0]        pred
);

  logic [T_BITS-1:0]     t;
  logic                  neg2;
  logic [COORD_BITS-1:0] h0_2;
  logic [PROD_BITS-1:0]  prod;
  logic                  neg3;
  logic [COORD_BITS-1:0] h0_3;

  logic [SUM_BITS-1:0]   sum_abs;
  logic [T_BITS-1:0]     q;
  logic [WIDE_BITS-1:0]  delta;
  logic [WIDE_BITS-1:0]  pred_wide;

  assign sum_abs = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);

  // Magnitude plus half the divisor, multiply by the reciprocal, then register the prediction.
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      t    <= sum_abs[T_BITS-1:0] + half(cnt_s1);
      neg2 <= sum[SUM_BITS-1];
      h0_2 <= h0;
    end
    if (adv.s3) begin
      prod <= PROD_BITS'(t) * PROD_BITS'(recip(cnt_s2));
      neg3 <= neg2;
      h0_3 <= h0_2;
    end
    if (adv.s4) begin
      pred <= pred_wide[OUT_BITS-1:0];
    end
  end

  assign q         = prod[K_SHIFT +: T_BITS];
  assign delta     = neg3 ? WIDE_BITS'(-WIDE_BITS'(q)) : WIDE_BITS'(q);
  assign pred_wide = WIDE_BITS'(h0_3) + delta;

endmodule

@@ design/weighted_motion_predictor.sv @@
// Top level: weighted-average motion predictor over a five-point history chain.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+---------------------
//  input   | center_x, center_y, restart               | in_valid / in_ready
//  output  | predicted_x, predicted_y, history_count   | out_valid / out_ready
//
// One request per cycle sustained while the output is not stalled; the history
// chain shifts once per request. An accepted request passes the sum stage,
// rounding, multiply and output register before its result goes valid.
// Reset clears the point count and all stage valid flags; history contents
// are left as they are, and zero-weight cells never pass them on.
// A stalled output holds only the full stages behind it; bubbles further up
// still close, so requests keep coming in while room remains.
`include "weighted_motion_predictor_macros.svh"

module weighted_motion_predictor
  import wmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_BITS-1:0]   predicted_x,
  output logic [OUT_BITS-1:0]   predicted_y,
  output logic [CNT_BITS-1:0]   history_count
);

  // Stage 0 is the history chain and point count, valid while its newest
  // request has not yet moved into the sum stage.
  logic                  v0, v1, v2, v3;
  logic [CNT_BITS-1:0]   cnt;
  logic [CNT_BITS-1:0]   cnt_next;
  logic [CNT_BITS-1:0]   cnt1, cnt2, cnt3;
  logic                  accept;
  logic                  cnt_grows;
  wmp_adv_t              adv;

  logic [COORD_BITS-1:0]       px [DEPTH];
  logic [COORD_BITS-1:0]       py [DEPTH];
  logic [CNT_BITS-1:0]         wgt [DEPTH];
  logic signed [TERM_BITS-1:0] tx [DEPTH];
  logic signed [TERM_BITS-1:0] ty [DEPTH];

  logic signed [SUM_BITS-1:0] sum_x_next, sum_y_next;
  logic signed [SUM_BITS-1:0] s1_sum_x, s1_sum_y;
  logic [COORD_BITS-1:0]      s1_h0x, s1_h0y;

  // Each stage advances when it is empty or the one after it advances.
  always_comb begin
    adv.s4 = !out_valid || out_ready;
    adv.s3 = !v3 || adv.s4;
    adv.s2 = !v2 || adv.s3;
    adv.s1 = !v1 || adv.s2;
  end

  assign in_ready = !v0 || adv.s1;
  assign accept   = in_valid && in_ready;

  // Restart, or an empty history, begins a new track with this point;
  // otherwise count up and saturate at the chain depth.
  always_comb begin
    if (restart || cnt == '0) begin
      cnt_next = CNT_BITS'(1);
    end else if (cnt < CNT_BITS'(DEPTH)) begin
      cnt_next = cnt + CNT_BITS'(1);
    end else begin
      cnt_next = CNT_BITS'(DEPTH);
    end
  end

  assign cnt_grows = accept && !restart && cnt != '0 && cnt < CNT_BITS'(DEPTH);

  // Weight of cell k is m - k for the m = count - 1 live differences.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      wgt[k] = (cnt > CNT_BITS'(k + 1)) ? cnt - CNT_BITS'(k + 1) : '0;
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [COORD_BITS-1:0] din_x, din_y, down_x, down_y;
    if (k == 0) begin : g_head
      assign din_x = center_x;
      assign din_y = center_y;
    end else begin : g_body
      assign din_x = px[k-1];
      assign din_y = py[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign down_x = px[k];
      assign down_y = py[k];
    end else begin : g_link
      assign down_x = px[k+1];
      assign down_y = py[k+1];
    end
    wmp_cell u_cell (
      .clk     (clk),
      .advance (accept),
      .din_x   (din_x),
      .din_y   (din_y),
      .down_x  (down_x),
      .down_y  (down_y),
      .weight  (wgt[k]),
      .point_x (px[k]),
      .point_y (py[k]),
      .term_x  (tx[k]),
      .term_y  (ty[k])
    );
  end

  // Add up the weighted differences; the oldest cell always has weight zero.
  always_comb begin
    sum_x_next = '0;
    sum_y_next = '0;
    for (int k = 0; k < DEPTH - 1; k++) begin
      sum_x_next = sum_x_next + SUM_BITS'(tx[k]);
      sum_y_next = sum_y_next + SUM_BITS'(ty[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt <= cnt_next;
      end
      if (accept) begin
        v0 <= 1'b1;
      end else if (adv.s1) begin
        v0 <= 1'b0;
      end
      if (adv.s1) v1 <= v0;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
      if (adv.s4) out_valid <= v3;
    end
  end

  // Payload side of the stages: hold while stalled.
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1_sum_x <= sum_x_next;
      s1_sum_y <= sum_y_next;
      s1_h0x   <= px[0];
      s1_h0y   <= py[0];
      cnt1     <= cnt;
    end
    if (adv.s2) cnt2 <= cnt1;
    if (adv.s3) cnt3 <= cnt2;
    if (adv.s4) history_count <= cnt3;
  end

  wmp_div u_div_x (
    .clk    (clk),
    .adv    (adv),
    .sum    (s1_sum_x),
    .h0     (s1_h0x),
    .cnt_s1 (cnt1),
    .cnt_s2 (cnt2),
    .pred   (predicted_x)
  );

  wmp_div u_div_y (
    .clk    (clk),
    .adv    (adv),
    .sum    (s1_sum_y),
    .h0     (s1_h0y),
    .cnt_s1 (cnt1),
    .cnt_s2 (cnt2),
    .pred   (predicted_y)
  );

  `WMP_ASSERT_NEXT(a_restart_one, accept && restart, cnt == CNT_BITS'(1))
  `WMP_ASSERT_NEXT(a_count_step, cnt_grows, cnt == $past(cnt) + CNT_BITS'(1))
  `WMP_ASSERT_NEXT(a_single_zero, v0 && adv.s1 && cnt <= CNT_BITS'(1), s1_sum_x == '0 && s1_sum_y == '0)
  `WMP_ASSERT_IMPL(a_empty_ready, !out_valid, in_ready)

endmodule

@@ bench/weighted_motion_predictor_test.sv @@
// Self-checking testbench for the weighted motion predictor: scoreboard, stimulus and checks.
module weighted_motion_predictor_test
  import wmp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 90;
  localparam int DRAIN_CYCLES = 16;

  // One predicted centre as it should leave the block.
  typedef struct {
    logic [OUT_BITS-1:0] x;
    logic [OUT_BITS-1:0] y;
    logic [CNT_BITS-1:0] count;
  } prediction_t;

  // Tracks the point history the same way the block does and queues the
  // prediction every accepted request must produce, in request order.
  class track_scoreboard;
    logic [COORD_BITS-1:0] trail_x[DEPTH];
    logic [COORD_BITS-1:0] trail_y[DEPTH];
    int unsigned           points;
    prediction_t           pending_predictions[$];
    int unsigned           errors;

    function new();
      points = 0;
      errors = 0;
      foreach (trail_x[i]) begin
        trail_x[i] = '0;
        trail_y[i] = '0;
      end
    endfunction

    // Newest point plus the weighted mean step, rounded half away from zero.
    function logic [OUT_BITS-1:0] extrapolate(input logic [COORD_BITS-1:0] h[DEPTH],
                                              input int unsigned n);
      longint steps;
      longint weight_total;
      longint mag;
      longint delta;
      int     m;
      m = int'(n) - 1;
      steps = 0;
      delta = 0;
      if (m > 0) begin
        for (int k = 0; k < m; k++)
          steps += (longint'(h[k]) - longint'(h[k+1])) * (m - k);
        weight_total = m * (m + 1) / 2;
        mag = (steps < 0) ? -steps : steps;
        delta = (2 * mag + weight_total) / (2 * weight_total);
        if (steps < 0)
          delta = -delta;
      end
      return OUT_BITS'(longint'(h[0]) + delta);
    endfunction

    function void note_request(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                               input logic new_track);
      prediction_t p;
      // A restart or an empty history opens a fresh track with this point.
      if (new_track || points == 0)
        points = 0;
      for (int i = DEPTH - 1; i > 0; i--) begin
        trail_x[i] = trail_x[i-1];
        trail_y[i] = trail_y[i-1];
      end
      trail_x[0] = x;
      trail_y[0] = y;
      if (points < DEPTH)
        points++;
      p.x = extrapolate(trail_x, points);
      p.y = extrapolate(trail_y, points);
      p.count = CNT_BITS'(points);
      pending_predictions.insert(pending_predictions.size(), p);
    endfunction

    function void check_result(input logic [OUT_BITS-1:0] px, input logic [OUT_BITS-1:0] py,
                               input logic [CNT_BITS-1:0] cnt);
      prediction_t e;
      if (pending_predictions.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      e = pending_predictions.pop_front();
      if (px !== e.x) begin
        $error("predicted_x: expected %0d, actual %0d", $signed(e.x), $signed(px));
        errors++;
      end
      if (py !== e.y) begin
        $error("predicted_y: expected %0d, actual %0d", $signed(e.y), $signed(py));
        errors++;
      end
      if (cnt !== e.count) begin
        $error("history_count: expected %0d, actual %0d", e.count, cnt);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_predictions.size();
    endfunction
  endclass

  // Every input starts known; reset is held from time zero.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COORD_BITS-1:0] center_x = '0;
  logic [COORD_BITS-1:0] center_y = '0;
  logic                  restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_BITS-1:0]   predicted_x;
  logic [OUT_BITS-1:0]   predicted_y;
  logic [CNT_BITS-1:0]   history_count;

  track_scoreboard scoreboard = new();

  // Idle and stall odds in percent, changed between test phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // The main sequence raises hold_request; the receiver then counts out a
  // long stretch with out_ready low on its own.
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  weighted_motion_predictor dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .center_x      (center_x),
    .center_y      (center_y),
    .restart       (restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .predicted_x   (predicted_x),
    .predicted_y   (predicted_y),
    .history_count (history_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: stall at random, or hold off for a counted stretch on request.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      scoreboard.check_result(predicted_x, predicted_y, history_count);
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one request and hold it until accepted. Call right after a rising
  // edge; returns at the edge of acceptance, so a following request can go
  // out in the same step without lowering valid in between.
  task automatic send_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic new_track);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    center_x <= x;
    center_y <= y;
    restart  <= new_track;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    scoreboard.note_request(x, y, new_track);
  endtask

  // Pause the sender until every outstanding prediction has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (scoreboard.pending() != 0)
      @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < 0)
      return '0;
    if (v > COORD_MAX)
      return COORD_BITS'(COORD_MAX);
    return COORD_BITS'(v);
  endfunction

  // Mostly plausible tracks (steady motion plus jitter, large jumps now and
  // then, clamped at the frame border); the rest is unrelated noise points.
  task automatic run_tracks(input int unsigned n_items);
    int unsigned sent;
    int          px;
    int          py;
    int          vx;
    int          vy;
    int          track_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        send_point(COORD_BITS'($urandom), COORD_BITS'($urandom), $urandom_range(0, 3) == 0);
        sent++;
      end else begin
        track_len = $urandom_range(1, 12);
        px = $urandom_range(0, COORD_MAX);
        py = $urandom_range(0, COORD_MAX);
        if ($urandom_range(0, 3) == 0) begin
          vx = int'($urandom_range(0, 4000)) - 2000;
          vy = int'($urandom_range(0, 4000)) - 2000;
        end else begin
          vx = int'($urandom_range(0, 40)) - 20;
          vy = int'($urandom_range(0, 40)) - 20;
        end
        for (int k = 0; k < track_len && sent < n_items; k++) begin
          // Usually open the track with a restart; sometimes run on from the last one.
          send_point(clamp_coord(px), clamp_coord(py), k == 0 && $urandom_range(0, 7) != 0);
          sent++;
          px = px + vx + int'($urandom_range(0, 4)) - 2;
          py = py + vy + int'($urandom_range(0, 4)) - 2;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: first point without restart on an empty history, full-scale
    // swings through every history depth, saturation at five points.
    send_point(12'd0, 12'd0, 1'b0);
    send_point(12'd4095, 12'd4095, 1'b0);
    send_point(12'd0, 12'd0, 1'b0);
    send_point(12'd4095, 12'd4095, 1'b0);
    send_point(12'd0, 12'd0, 1'b0);
    send_point(12'd4095, 12'd0, 1'b0);
    // Restart over a full history, then the most negative and most positive
    // predictions.
    send_point(12'd4095, 12'd0, 1'b1);
    send_point(12'd0, 12'd4095, 1'b0);
    // Exact halves at five points: weighted sums of +5 and -5 over ten.
    send_point(12'd100, 12'd100, 1'b1);
    send_point(12'd101, 12'd99, 1'b0);
    send_point(12'd101, 12'd99, 1'b0);
    send_point(12'd101, 12'd99, 1'b0);
    send_point(12'd102, 12'd98, 1'b0);
    // Exact halves at four points: sums of +3 and -3 over six.
    send_point(12'd200, 12'd200, 1'b1);
    send_point(12'd200, 12'd200, 1'b0);
    send_point(12'd200, 12'd200, 1'b0);
    send_point(12'd201, 12'd199, 1'b0);
    // Back-to-back restarts keep the history at one point.
    send_point(12'd0, 12'd0, 1'b1);
    send_point(12'd2730, 12'd1365, 1'b1);
    send_point(12'd1365, 12'd2730, 1'b0);
    send_point(12'd2048, 12'd2047, 1'b0);
    wait_drain();

    // Random phases: no idling, sender idle, receiver stalling, both.
    run_tracks(220);
    send_idle_pct = 51;
    run_tracks(220);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    run_tracks(220);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    run_tracks(200);

    // Backpressure: hold the receiver off while requests keep coming, so the
    // pipeline fills and drops in_ready; then pause until it drains.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b1;
    run_tracks(40);
    wait_drain();

    while (scoreboard.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scoreboard.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/wmp_pkg.sv
design/wmp_cell.sv
design/wmp_div.sv
design/weighted_motion_predictor.sv
bench/weighted_motion_predictor_test.sv
